// ----- rtl/core/deadline_priority_queue_unit_macros.svh -----
// Assertion macros used by the deadline priority queue top level.
`ifndef DEADLINE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPQ_ASSERT_IMPLY_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dpq_pkg.sv -----
// Package with widths, codes and record types of the deadline priority queue.
`default_nettype none

package dpq_pkg;

    // Store geometry.
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int WEIGHT_W = 31;
    localparam int VALUE_W  = 31;
    localparam int TIME_W   = 32;

    // Request actions.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SERVE  = 1'b1;

    // Entry kinds; the last code stores nothing on insert.
    localparam logic [KIND_W-1:0] KIND_PERM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LATE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_VOID   = 2'd3;

    // Input request payload.
    typedef struct packed {
        logic                action;
        logic [KIND_W-1:0]   kind;
        logic [WEIGHT_W-1:0] weight;
        logic [VALUE_W-1:0]  item_value;
        logic [TIME_W-1:0]   deadline;
        logic [WEIGHT_W-1:0] late_weight;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic               served;
        logic [VALUE_W-1:0] served_value;
        logic               rejected;
    } t_rsp;

    // One stored entry as it lies in the memory.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WEIGHT_W-1:0] weight;
        logic [VALUE_W-1:0]  payload;
        logic [TIME_W-1:0]   deadline;
        logic [WEIGHT_W-1:0] late_weight;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Write-back and valid-bit update produced by the aging stage.
    typedef struct packed {
        logic             wr_en;
        logic             clr_valid;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wb;

    // One aged entry handed to the selection stage.
    typedef struct packed {
        logic                live;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] weight;
        logic [TIME_W-1:0]   age;
        logic [VALUE_W-1:0]  payload;
    } t_cand;

    // Outcome of one sweep: best live entry and lowest free slot.
    typedef struct packed {
        logic               found_best;
        logic [IDX_W-1:0]   best_idx;
        logic [VALUE_W-1:0] best_payload;
        logic               found_free;
        logic [IDX_W-1:0]   free_idx;
    } t_pick;

endpackage

`default_nettype wire

// ----- rtl/core/dpq_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface dpq_req_if import dpq_pkg::*; ();
    logic valid;
    logic ready;
    t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface dpq_rsp_if import dpq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dpq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/dpq_age.sv -----
// Aging stage: applies deadline rules to one read entry and computes its age.
`default_nettype none

module dpq_age import dpq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic              i_live,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_entry            i_data,
    input  wire logic [TIME_W-1:0] i_now,
    output t_wb                    o_wb,
    output logic                   o_cand_vld,
    output t_cand                  o_cand
);

    logic   w_passed;
    logic   w_expired;
    logic   w_relabel;
    t_entry w_aged;
    logic   r_cand_vld;
    t_cand  r_cand;

    // Deadline tests against the current time.
    assign w_passed  = (i_data.deadline < i_now);
    assign w_expired = (i_data.kind == KIND_EXPIRE) && (i_data.deadline != '0) && w_passed;
    assign w_relabel = (i_data.kind == KIND_LATE) && w_passed;

    // A late entry past its deadline becomes permanent and ranks by its late weight.
    always_comb begin
        w_aged = i_data;
        if (w_relabel) begin
            w_aged.kind   = KIND_PERM;
            w_aged.weight = i_data.late_weight;
        end
    end

    // Write back relabeled entries and drop expired ones.
    assign o_wb.wr_en     = i_vld && i_live && w_relabel;
    assign o_wb.clr_valid = i_vld && i_live && w_expired;
    assign o_wb.idx       = i_idx;
    assign o_wb.data      = w_aged;

    // Register the candidate for the selection stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand.live    <= i_live && !w_expired;
        r_cand.idx     <= i_idx;
        r_cand.weight  <= w_aged.weight;
        r_cand.age     <= i_now - i_data.stamp;
        r_cand.payload <= i_data.payload;
    end

    assign o_cand_vld = r_cand_vld;
    assign o_cand     = r_cand;

endmodule

`default_nettype wire

// ----- rtl/core/dpq_select.sv -----
// Selection stage: tracks the best live entry and the lowest free slot of a sweep.
`default_nettype none

module dpq_select import dpq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_cand_vld,
    input  wire t_cand i_cand,
    output t_pick      o_pick
);

    logic                r_found_best;
    logic [IDX_W-1:0]    r_best_idx;
    logic [VALUE_W-1:0]  r_best_payload;
    logic [WEIGHT_W-1:0] r_best_w;
    logic [TIME_W-1:0]   r_best_age;
    logic                r_found_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic                w_better;

    // Smaller weight wins; on equal weight the older entry wins.
    assign w_better = !r_found_best || (i_cand.weight < r_best_w) ||
                      ((i_cand.weight == r_best_w) && (i_cand.age > r_best_age));

    // Flags restart with every request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_best <= 1'b0;
            r_found_free <= 1'b0;
        end else if (i_start) begin
            r_found_best <= 1'b0;
            r_found_free <= 1'b0;
        end else if (i_cand_vld) begin
            if (i_cand.live) begin
                r_found_best <= 1'b1;
            end else begin
                r_found_free <= 1'b1;
            end
        end
    end

    // Payload of the running best and the first free slot.
    always_ff @(posedge i_clk) begin
        if (i_cand_vld && !i_start) begin
            if (i_cand.live && w_better) begin
                r_best_idx     <= i_cand.idx;
                r_best_payload <= i_cand.payload;
                r_best_w       <= i_cand.weight;
                r_best_age     <= i_cand.age;
            end
            if (!i_cand.live && !r_found_free) begin
                r_free_idx <= i_cand.idx;
            end
        end
    end

    assign o_pick.found_best   = r_found_best;
    assign o_pick.best_idx     = r_best_idx;
    assign o_pick.best_payload = r_best_payload;
    assign o_pick.found_free   = r_found_free;
    assign o_pick.free_idx     = r_free_idx;

endmodule

`default_nettype wire

// ----- rtl/core/deadline_priority_queue_unit.sv -----
// Deadline priority queue: entries live in one memory and every request sweeps it.
// The sweep reads one entry per cycle through the memory's single read port, and the result
// is registered once the drain through the aging and selection stages is done. One request
// is in work at a time; a new one is taken while the last result waits, and its own result
// then holds until that is taken. Reset (synchronous, active low) empties the store and
// zeroes time; no clearing pass.
`default_nettype none
`include "deadline_priority_queue_unit_macros.svh"

module deadline_priority_queue_unit import dpq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dpq_req_if.sink    i_req,
    dpq_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [TIME_W-1:0]  r_time;
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_s1_vld;
    logic               r_s1_last;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s2_last;
    t_req               r_req;
    logic               r_out_vld;
    t_rsp               r_out;
    t_rsp               n_out;

    logic               w_accept;
    logic               w_last_rd;
    logic               w_commit;
    logic               w_ins;
    logic               w_take;
    logic               w_ram_we;
    logic [IDX_W-1:0]   w_ram_waddr;
    t_entry             w_ram_wdata;
    logic               w_ram_re;
    logic [IDX_W-1:0]   w_ram_raddr;
    logic [ENTRY_W-1:0] w_ram_rdata;
    t_entry             w_new;
    t_wb                w_wb;
    logic               w_cand_vld;
    t_cand              w_cand;
    t_pick              w_pick;

    // Handshakes.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.rsp   = r_out;
    assign w_last_rd   = (r_rd_idx == IDX_W'(ENTRIES - 1));
    assign w_commit    = (r_state == S_FINISH) && (!r_out_vld || o_rsp.ready);
    assign w_ins       = w_commit && (r_req.action == ACT_INSERT) &&
                         (r_req.kind != KIND_VOID) && w_pick.found_free;
    assign w_take      = w_commit && (r_req.action == ACT_SERVE) && w_pick.found_best;

    // Record written by an insert.
    always_comb begin
        w_new.kind        = r_req.kind;
        w_new.weight      = r_req.weight;
        w_new.payload     = r_req.item_value;
        w_new.deadline    = r_req.deadline;
        w_new.late_weight = r_req.late_weight;
        w_new.stamp       = r_time;
    end

    // Memory ports: the sweep reads entry i while writing back entry i-1, and the
    // insert writes only after the sweep, so read and write never hit one entry.
    assign w_ram_re    = (r_state == S_SWEEP);
    assign w_ram_raddr = r_rd_idx;
    assign w_ram_we    = w_wb.wr_en || w_ins;
    assign w_ram_waddr = w_ins ? w_pick.free_idx : w_wb.idx;
    assign w_ram_wdata = w_ins ? w_new : w_wb.data;

    dpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_ram_raddr),
        .o_rd_data (w_ram_rdata)
    );

    dpq_age u_age (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_s1_vld),
        .i_live     (r_s1_vld && r_valid[r_s1_idx]),
        .i_idx      (r_s1_idx),
        .i_data     (t_entry'(w_ram_rdata)),
        .i_now      (r_time),
        .o_wb       (w_wb),
        .o_cand_vld (w_cand_vld),
        .o_cand     (w_cand)
    );

    dpq_select u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_cand_vld (w_cand_vld),
        .i_cand     (w_cand),
        .o_pick     (w_pick)
    );

    // Result of the finished sweep.
    always_comb begin
        n_out = '0;
        if (r_req.action == ACT_SERVE) begin
            n_out.served = w_pick.found_best;
            if (w_pick.found_best) begin
                n_out.served_value = w_pick.best_payload;
            end
        end else if (r_req.kind != KIND_VOID) begin
            n_out.rejected = !w_pick.found_free;
        end
    end

    // Sequencer, time counter, valid bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_time    <= '0;
            r_valid   <= '0;
            r_rd_idx  <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= (r_state == S_SWEEP);
            r_s1_last <= (r_state == S_SWEEP) && w_last_rd;
            r_s2_last <= r_s1_last;
            if (w_wb.clr_valid) begin
                r_valid[w_wb.idx] <= 1'b0;
            end
            if (o_rsp.valid && o_rsp.ready && !w_commit) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_time   <= r_time + TIME_W'(1);
                        r_rd_idx <= '0;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (w_last_rd) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_s2_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_commit) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                        if (w_ins) begin
                            r_valid[w_pick.free_idx] <= 1'b1;
                        end
                        if (w_take) begin
                            r_valid[w_pick.best_idx] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.req;
        end
        if (r_state == S_SWEEP) begin
            r_s1_idx <= r_rd_idx;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    // Checks on sequencing and memory use.
    `DPQ_ASSERT_IMPLY_NEXT(a_accept_starts_sweep, i_clk, i_rst_n, w_accept, r_state == S_SWEEP, "request accepted without starting a sweep")
    `DPQ_ASSERT_IMPLY_NEXT(a_time_steps_once, i_clk, i_rst_n, w_accept, r_time == $past(r_time) + TIME_W'(1), "time did not advance by one on a request")
    `DPQ_ASSERT_IMPLY(a_ram_no_collision, i_clk, i_rst_n, w_ram_we && w_ram_re, w_ram_waddr != w_ram_raddr, "memory read and write hit the same entry")
    `DPQ_ASSERT_IMPLY(a_insert_into_free, i_clk, i_rst_n, w_ins, !r_valid[w_pick.free_idx], "insert overwrites a live entry")

endmodule

`default_nettype wire
